>>> hdl/distributed_mutex_node_core_macros.svh
// Assertion macros for the distributed mutex node core.
// Used by the top level only; relies on clk_i and rst_ni in the including scope.
`ifndef DISTRIBUTED_MUTEX_NODE_CORE_MACROS_SVH
`define DISTRIBUTED_MUTEX_NODE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DMN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("distributed_mutex_node_core: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DMN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("distributed_mutex_node_core: next-cycle check failed");

`endif

>>> hdl/dmn_pkg.sv
// Shared types, codes and sizing constants for the distributed mutex node.
// No dependencies; imported by dmn_ctrl, dmn_datapath and the top level.
`default_nettype none

package dmn_pkg;

  localparam int NODE_COUNT = 8;
  // Ranks are 3 bits wide, so at most eight nodes take part.
  localparam int EFF_NODES  = (NODE_COUNT > 8) ? 8 : NODE_COUNT;
  localparam int NEEDED     = EFF_NODES - 1;
  localparam int QDEPTH     = 7;

  localparam int RANK_W  = 3;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 3;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 2;

  // Input operations
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_MESSAGE = 2'd2;

  // Message kinds, received and sent
  localparam logic [KIND_W-1:0] MSG_REQ = 2'd0;
  localparam logic [KIND_W-1:0] MSG_ACK = 2'd1;
  localparam logic [KIND_W-1:0] MSG_FIN = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] RK_MESSAGE = 2'd0;
  localparam logic [KIND_W-1:0] RK_ENTERED = 2'd1;
  localparam logic [KIND_W-1:0] RK_ALLDONE = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_REQ,
    MODE_CS
  } node_mode_e;

  // What the datapath emits after one event
  typedef enum logic [1:0] {
    PLAN_NONE,
    PLAN_BCAST,
    PLAN_DRAIN,
    PLAN_SINGLE
  } plan_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic step;
  } dmn_cmd_t;

  typedef struct packed {
    logic emit_any;
    logic last;
  } dmn_status_t;

endpackage

`default_nettype wire

>>> hdl/dmn_ctrl.sv
// Sequencer for the distributed mutex node: accept, execute, emit results.
// Depends on dmn_pkg for the command and status structs.
`default_nettype none

module dmn_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  dmn_pkg::dmn_status_t status_i,
  output dmn_pkg::dmn_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 valid_o
);
  import dmn_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.step    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.emit_any ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_EMIT);

endmodule

`default_nettype wire

>>> hdl/dmn_datapath.sv
// Node state, Lamport clock, deferred queue and result field generation.
// Depends on dmn_pkg; driven by commands from dmn_ctrl.
`default_nettype none

module dmn_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dmn_pkg::dmn_cmd_t             cmd_i,
  output dmn_pkg::dmn_status_t          status_o,
  input  logic                          cfg_we_i,
  input  logic [dmn_pkg::RANK_W-1:0]    cfg_data_i,
  input  logic [dmn_pkg::OP_W-1:0]      operation_i,
  input  logic [dmn_pkg::KIND_W-1:0]    msg_kind_i,
  input  logic [dmn_pkg::STAMP_W-1:0]   msg_stamp_i,
  input  logic [dmn_pkg::RANK_W-1:0]    msg_origin_i,
  output logic [dmn_pkg::KIND_W-1:0]    result_kind_o,
  output logic [dmn_pkg::KIND_W-1:0]    send_kind_o,
  output logic [dmn_pkg::STAMP_W-1:0]   send_stamp_o,
  output logic [dmn_pkg::RANK_W-1:0]    send_target_o,
  output logic                          last_o
);
  import dmn_pkg::*;

  // Captured event
  logic [OP_W-1:0]    op_q;
  logic [KIND_W-1:0]  kind_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [RANK_W-1:0]  origin_q;

  // Node state
  logic [RANK_W-1:0]  own_rank_q;
  logic [STAMP_W-1:0] clock_q, clock_d;
  node_mode_e         mode_q, mode_d;
  logic [STAMP_W-1:0] req_stamp_q, req_stamp_d;
  logic [CNT_W-1:0]   acks_q, acks_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   fin_q, fin_d;
  logic [RANK_W-1:0]  deferred_q [QDEPTH];

  // Emission sequencing
  plan_e              plan_q, plan_d;
  logic [RANK_W-1:0]  idx_q, idx_d, idx_next;
  logic [RANK_W-1:0]  end_q, end_d;
  logic [KIND_W-1:0]  rkind_q, rkind_d;

  logic               enq;
  logic               grant;
  logic [STAMP_W-1:0] max_stamp;
  logic [CNT_W-1:0]   acks_sat;
  logic [RANK_W-1:0]  bcast_next;

  always_comb begin
    max_stamp   = (clock_q < stamp_q) ? stamp_q : clock_q;
    grant       = (mode_q == MODE_IDLE) ||
                  ((mode_q == MODE_REQ) &&
                   ((stamp_q < req_stamp_q) ||
                    ((stamp_q == req_stamp_q) && (origin_q < own_rank_q))));
    acks_sat    = (acks_q < CNT_W'(7)) ? acks_q + CNT_W'(1) : acks_q;

    clock_d     = clock_q;
    mode_d      = mode_q;
    req_stamp_d = req_stamp_q;
    acks_d      = acks_q;
    count_d     = count_q;
    fin_d       = fin_q;
    plan_d      = PLAN_NONE;
    idx_d       = '0;
    end_d       = '0;
    rkind_d     = RK_MESSAGE;
    enq         = 1'b0;

    case (op_q)
      OP_REQUEST: begin
        if (mode_q == MODE_IDLE) begin
          clock_d     = clock_q + STAMP_W'(1);
          req_stamp_d = clock_q + STAMP_W'(1);
          acks_d      = '0;
          mode_d      = MODE_REQ;
          plan_d      = PLAN_BCAST;
          // skip own rank at both ends of the sweep
          idx_d       = (own_rank_q == '0) ? RANK_W'(1) : '0;
          end_d       = (own_rank_q == RANK_W'(EFF_NODES - 1)) ?
                        RANK_W'(EFF_NODES - 2) : RANK_W'(EFF_NODES - 1);
        end
      end
      OP_RELEASE: begin
        if (mode_q == MODE_CS) begin
          clock_d = clock_q + STAMP_W'(1);
          mode_d  = MODE_IDLE;
          count_d = '0;
          if (count_q != '0) begin
            plan_d = PLAN_DRAIN;
            end_d  = RANK_W'(count_q - CNT_W'(1));
          end
        end
      end
      OP_MESSAGE: begin
        case (kind_q)
          MSG_REQ: begin
            if (grant) begin
              clock_d = max_stamp + STAMP_W'(2);
              plan_d  = PLAN_SINGLE;
              rkind_d = RK_MESSAGE;
            end else begin
              clock_d = max_stamp + STAMP_W'(1);
              if (count_q < CNT_W'(QDEPTH)) begin
                enq     = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
          end
          MSG_ACK: begin
            clock_d = max_stamp + STAMP_W'(1);
            if (mode_q == MODE_REQ) begin
              acks_d = acks_sat;
              if (acks_sat >= CNT_W'(NEEDED)) begin
                mode_d  = MODE_CS;
                clock_d = max_stamp + STAMP_W'(2);
                plan_d  = PLAN_SINGLE;
                rkind_d = RK_ENTERED;
              end
            end
          end
          MSG_FIN: begin
            clock_d = max_stamp + STAMP_W'(1);
            if (fin_q < CNT_W'(NEEDED)) begin
              fin_d = fin_q + CNT_W'(1);
              if (fin_q + CNT_W'(1) == CNT_W'(NEEDED)) begin
                plan_d  = PLAN_SINGLE;
                rkind_d = RK_ALLDONE;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    bcast_next = idx_q + RANK_W'(1);
    if (bcast_next == own_rank_q) begin
      bcast_next = idx_q + RANK_W'(2);
    end
    idx_next = (plan_q == PLAN_BCAST) ? bcast_next : idx_q + RANK_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      kind_q   <= msg_kind_i;
      stamp_q  <= msg_stamp_i;
      origin_q <= msg_origin_i;
    end
    if (cmd_i.exec) begin
      end_q   <= end_d;
      rkind_q <= rkind_d;
      if (enq) begin
        deferred_q[count_q] <= origin_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_rank_q  <= '0;
      clock_q     <= '0;
      mode_q      <= MODE_IDLE;
      req_stamp_q <= '0;
      acks_q      <= '0;
      count_q     <= '0;
      fin_q       <= '0;
      plan_q      <= PLAN_NONE;
      idx_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        own_rank_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        clock_q     <= clock_d;
        mode_q      <= mode_d;
        req_stamp_q <= req_stamp_d;
        acks_q      <= acks_d;
        count_q     <= count_d;
        fin_q       <= fin_d;
        plan_q      <= plan_d;
        idx_q       <= idx_d;
      end else if (cmd_i.step) begin
        idx_q <= idx_next;
      end
    end
  end

  // Result fields for the current beat
  always_comb begin
    result_kind_o = RK_MESSAGE;
    send_kind_o   = MSG_REQ;
    send_stamp_o  = clock_q;
    send_target_o = idx_q;
    case (plan_q)
      PLAN_BCAST: begin
        send_kind_o = MSG_REQ;
      end
      PLAN_DRAIN: begin
        send_kind_o   = MSG_ACK;
        send_target_o = (idx_q < RANK_W'(QDEPTH)) ? deferred_q[idx_q] : '0;
      end
      PLAN_SINGLE: begin
        result_kind_o = rkind_q;
        if (rkind_q == RK_MESSAGE) begin
          send_kind_o   = MSG_ACK;
          send_target_o = origin_q;
        end else begin
          send_stamp_o  = '0;
          send_target_o = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign last_o            = (idx_q == end_q);
  assign status_o.last     = (idx_q == end_q);
  assign status_o.emit_any = (plan_d != PLAN_NONE);

endmodule

`default_nettype wire

>>> hdl/distributed_mutex_node_core.sv
// Top level of one Ricart-Agrawala mutual exclusion node with a Lamport clock.
// Depends on dmn_pkg, dmn_ctrl, dmn_datapath and the assertion macro header.
// Usage:
//   Event channel: drive operation_i, msg_kind_i, msg_stamp_i and msg_origin_i
//   with start high; the beat is taken at the rising edge where busy is low.
//   Result channel: each result beat stands on the result ports for exactly one
//   cycle with result_valid_o high; last_o marks the final beat of an event.
//   The receiver cannot stall, so beats leave back to back without gaps.
//   Configuration: write own rank by cfg_we_i/cfg_data_i only while idle; the block does not enforce this.
// Timing:
//   After the accept edge the block runs its execute state, in which the clock,
//   mode, counters and deferred queue update, then emits the result beats back to back.
//   Busy stays high until the final beat of an event has left, so the next
//   event is taken only after the previous one is done.
//   A local request sends up to seven REQ beats; a release sends one ACK per
//   deferred node; the emit counter in the datapath sets these lengths.
//   Events with no result (ignored requests, queued REQs, plain ACKs) end after execute.
// Reset:
//   rst_ni low clears the Lamport clock, mode, counters and own rank at once.
//   The deferred queue is not cleared; entries are read only after written.
`default_nettype none

`include "distributed_mutex_node_core_macros.svh"

module distributed_mutex_node_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [dmn_pkg::RANK_W-1:0]    cfg_data_i,
  input  logic [dmn_pkg::OP_W-1:0]      operation_i,
  input  logic [dmn_pkg::KIND_W-1:0]    msg_kind_i,
  input  logic [dmn_pkg::STAMP_W-1:0]   msg_stamp_i,
  input  logic [dmn_pkg::RANK_W-1:0]    msg_origin_i,
  output logic                          result_valid_o,
  output logic [dmn_pkg::KIND_W-1:0]    result_kind_o,
  output logic [dmn_pkg::KIND_W-1:0]    send_kind_o,
  output logic [dmn_pkg::STAMP_W-1:0]   send_stamp_o,
  output logic [dmn_pkg::RANK_W-1:0]    send_target_o,
  output logic                          last_o
);
  import dmn_pkg::*;

  dmn_cmd_t    cmd;
  dmn_status_t status;
  logic        accept;

  // Take a new event only while the sequencer rests
  assign accept = start & ~busy;

  dmn_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .valid_o  (result_valid_o)
  );

  dmn_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .operation_i   (operation_i),
    .msg_kind_i    (msg_kind_i),
    .msg_stamp_i   (msg_stamp_i),
    .msg_origin_i  (msg_origin_i),
    .result_kind_o (result_kind_o),
    .send_kind_o   (send_kind_o),
    .send_stamp_o  (send_stamp_o),
    .send_target_o (send_target_o),
    .last_o        (last_o)
  );

  // A result beat only appears while an event is in flight
  `DMN_ASSERT_NOW(a_valid_busy, result_valid_o, busy)
  // An accepted event holds the block busy for its execute cycle
  `DMN_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Result beats of one event leave without gaps
  `DMN_ASSERT_NEXT(a_burst_cont, result_valid_o && !last_o, result_valid_o)
  // The final beat frees the block for the next event
  `DMN_ASSERT_NEXT(a_last_frees, result_valid_o && last_o, !busy)

endmodule

`default_nettype wire

>>> tb/dmn_event_checker.sv
// Watches the event and result channels of the distributed mutex node core, mirrors
// the node state, predicts the result beats of each event and compares them in order.
// Depends on dmn_pkg for widths, codes and the node mode type.
module dmn_event_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic                         cfg_we_i,
  input  logic [dmn_pkg::RANK_W-1:0]   cfg_data_i,
  input  logic [dmn_pkg::OP_W-1:0]     operation_i,
  input  logic [dmn_pkg::KIND_W-1:0]   msg_kind_i,
  input  logic [dmn_pkg::STAMP_W-1:0]  msg_stamp_i,
  input  logic [dmn_pkg::RANK_W-1:0]   msg_origin_i,
  input  logic                         result_valid_i,
  input  logic [dmn_pkg::KIND_W-1:0]   result_kind_i,
  input  logic [dmn_pkg::KIND_W-1:0]   send_kind_i,
  input  logic [dmn_pkg::STAMP_W-1:0]  send_stamp_i,
  input  logic [dmn_pkg::RANK_W-1:0]   send_target_i,
  input  logic                         last_i,
  output int                           errors_o,
  output int                           owed_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dmn_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]  rkind;
    logic [KIND_W-1:0]  skind;
    logic [STAMP_W-1:0] stamp;
    logic [RANK_W-1:0]  target;
    logic               last;
  } beat_t;

  beat_t              owed_q[$];
  logic [RANK_W-1:0]  node_rank;
  logic [STAMP_W-1:0] clock_now;
  logic [STAMP_W-1:0] my_stamp;
  node_mode_e         mode_now;
  logic [CNT_W-1:0]   ack_tally;
  logic [CNT_W-1:0]   fin_tally;
  logic [CNT_W-1:0]   held_count;
  logic [RANK_W-1:0]  held_ranks [QDEPTH];
  int                 error_count = 0;

  assign errors_o = error_count;

  task automatic report_failure(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [STAMP_W-1:0] got,
                             input logic [STAMP_W-1:0] want);
    if (got !== want) begin
      report_failure($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  function automatic void owe(input logic [KIND_W-1:0] rk, input logic [KIND_W-1:0] sk,
                              input logic [STAMP_W-1:0] st, input logic [RANK_W-1:0] tg);
    beat_t b;
    b.rkind  = rk;
    b.skind  = sk;
    b.stamp  = st;
    b.target = tg;
    b.last   = 1'b0;
    owed_q.push_back(b);
  endfunction

  // Advance the mirror by one event and queue the beats it must produce.
  function automatic void predict_event(input logic [OP_W-1:0] op,
                                        input logic [KIND_W-1:0] kind,
                                        input logic [STAMP_W-1:0] stamp,
                                        input logic [RANK_W-1:0] origin);
    int    first;
    int    r;
    logic  grant;
    beat_t tail;
    first = owed_q.size();
    case (op)
      OP_REQUEST: begin
        if (mode_now == MODE_IDLE) begin
          clock_now = clock_now + 32'd1;
          my_stamp  = clock_now;
          ack_tally = '0;
          mode_now  = MODE_REQ;
          for (r = 0; r < EFF_NODES; r++) begin
            if (r != int'(node_rank)) owe(RK_MESSAGE, MSG_REQ, clock_now, RANK_W'(r));
          end
          if (NEEDED == 0) begin
            mode_now  = MODE_CS;
            clock_now = clock_now + 32'd1;
            owe(RK_ENTERED, MSG_REQ, '0, '0);
          end
        end
      end
      OP_RELEASE: begin
        if (mode_now == MODE_CS) begin
          clock_now = clock_now + 32'd1;
          mode_now  = MODE_IDLE;
          for (r = 0; r < int'(held_count); r++) begin
            owe(RK_MESSAGE, MSG_ACK, clock_now, held_ranks[r]);
          end
          held_count = '0;
        end
      end
      OP_MESSAGE: begin
        if (kind == MSG_REQ || kind == MSG_ACK || kind == MSG_FIN) begin
          if (clock_now < stamp) clock_now = stamp;
          clock_now = clock_now + 32'd1;
        end
        case (kind)
          MSG_REQ: begin
            grant = (mode_now == MODE_IDLE) ||
                    (mode_now == MODE_REQ &&
                     (stamp < my_stamp || (stamp == my_stamp && origin < node_rank)));
            if (grant) begin
              clock_now = clock_now + 32'd1;
              owe(RK_MESSAGE, MSG_ACK, clock_now, origin);
            end else if (int'(held_count) < QDEPTH) begin
              held_ranks[held_count] = origin;
              held_count = held_count + CNT_W'(1);
            end
          end
          MSG_ACK: begin
            if (mode_now == MODE_REQ) begin
              if (ack_tally != '1) ack_tally = ack_tally + CNT_W'(1);
              if (ack_tally >= CNT_W'(NEEDED)) begin
                mode_now  = MODE_CS;
                clock_now = clock_now + 32'd1;
                owe(RK_ENTERED, MSG_REQ, '0, '0);
              end
            end
          end
          MSG_FIN: begin
            if (fin_tally < CNT_W'(NEEDED)) begin
              fin_tally = fin_tally + CNT_W'(1);
              if (fin_tally == CNT_W'(NEEDED)) owe(RK_ALLDONE, MSG_REQ, '0, '0);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (owed_q.size() > first) begin
      tail = owed_q.pop_back();
      tail.last = 1'b1;
      owed_q.push_back(tail);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    beat_t want;
    if (!rst_ni) begin
      node_rank  = '0;
      clock_now  = '0;
      my_stamp   = '0;
      mode_now   = MODE_IDLE;
      ack_tally  = '0;
      fin_tally  = '0;
      held_count = '0;
      owed_q.delete();
      owed_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (owed_q.size() == 0) begin
          report_failure($sformatf("unexpected beat kind %0d target %0d stamp 0x%0h",
                                   result_kind_i, send_target_i, send_stamp_i));
        end else begin
          want = owed_q.pop_front();
          check_field("result_kind", result_kind_i, want.rkind);
          check_field("send_kind", send_kind_i, want.skind);
          check_field("send_stamp", send_stamp_i, want.stamp);
          check_field("send_target", send_target_i, want.target);
          check_field("last", last_i, want.last);
        end
      end
      if (cfg_we_i) node_rank = cfg_data_i;
      if (start_i && !busy_i) begin
        predict_event(operation_i, msg_kind_i, msg_stamp_i, msg_origin_i);
      end
      owed_o <= owed_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// Top of the distributed mutex node core testbench: makes clock, reset, rank
// writes and event beats with random gaps, then gives the verdict.
// Depends on dmn_pkg, distributed_mutex_node_core and dmn_event_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmn_pkg::*;

  localparam int RANDOM_ITEMS = 260;
  localparam int PHASES       = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int QUIET_CYCLES = 6;     // covers an event with no result
  localparam int IDLE_PERCENT = 37;
  localparam int MAX_GAP      = 12;

  // Codes the block does not know; it must ignore them.
  localparam logic [OP_W-1:0]   OP_UNKNOWN  = 2'd3;
  localparam logic [KIND_W-1:0] MSG_UNKNOWN = 2'd3;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start        = 1'b0;
  logic                busy;
  logic                cfg_we_i     = 1'b0;
  logic [RANK_W-1:0]   cfg_data_i   = '0;
  logic [OP_W-1:0]     operation_i  = OP_REQUEST;
  logic [KIND_W-1:0]   msg_kind_i   = MSG_REQ;
  logic [STAMP_W-1:0]  msg_stamp_i  = '0;
  logic [RANK_W-1:0]   msg_origin_i = '0;
  logic                result_valid_o;
  logic [KIND_W-1:0]   result_kind_o;
  logic [KIND_W-1:0]   send_kind_o;
  logic [STAMP_W-1:0]  send_stamp_o;
  logic [RANK_W-1:0]   send_target_o;
  logic                last_o;

  int                  fail_count;
  int                  owed_count;
  int                  cycle_count = 0;
  int                  items_sent  = 0;
  bit                  gaps_on     = 1'b1;
  logic [STAMP_W-1:0]  last_bcast_stamp = '0;

  distributed_mutex_node_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .msg_kind_i     (msg_kind_i),
    .msg_stamp_i    (msg_stamp_i),
    .msg_origin_i   (msg_origin_i),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .send_kind_o    (send_kind_o),
    .send_stamp_o   (send_stamp_o),
    .send_target_o  (send_target_o),
    .last_o         (last_o)
  );

  dmn_event_checker event_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .msg_kind_i     (msg_kind_i),
    .msg_stamp_i    (msg_stamp_i),
    .msg_origin_i   (msg_origin_i),
    .result_valid_i (result_valid_o),
    .result_kind_i  (result_kind_o),
    .send_kind_i    (send_kind_o),
    .send_stamp_i   (send_stamp_o),
    .send_target_i  (send_target_o),
    .last_i         (last_o),
    .errors_o       (fail_count),
    .owed_o         (owed_count)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop: a hung handshake or a lost beat ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("distributed_mutex_node_core test failed");
      $finish;
    end
  end

  // Track the stamp of our own latest request so peer REQs can land on,
  // just below or just above it (tie-break by rank included).
  always @(posedge clk_i) begin
    if (result_valid_o && result_kind_o == RK_MESSAGE && send_kind_o == MSG_REQ) begin
      last_bcast_stamp <= send_stamp_o;
    end
  end

  function automatic logic [STAMP_W-1:0] pick_stamp();
    logic [STAMP_W-1:0] s;
    case ($urandom_range(7))
      0:       s = '0;
      1:       s = '1;
      2:       s = last_bcast_stamp - 32'd1;
      3:       s = last_bcast_stamp;
      4:       s = last_bcast_stamp + 32'd1;
      5:       s = $urandom;
      default: s = 32'($urandom_range(64));
    endcase
    return s;
  endfunction

  // Offer one event beat, optionally after an idle gap, and hold it until taken.
  task automatic issue_event(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                             input logic [STAMP_W-1:0] stamp,
                             input logic [RANK_W-1:0] origin);
    if (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    msg_kind_i   <= kind;
    msg_stamp_i  <= stamp;
    msg_origin_i <= origin;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop start and let every owed beat drain, then give the block time to settle
  // after events that produce nothing.
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_rank(input logic [RANK_W-1:0] rank);
    wait_quiet();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= rank;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One mutual exclusion round: request, gather ACKs while peers compete with
  // their own REQs, hold the section while more REQs queue up, then release.
  // Now and then an ACK is missing or the release is skipped, leaving the node
  // stuck in a state that the next round has to run into.
  task automatic run_session();
    int acks_left;
    int queued;
    acks_left = ($urandom_range(9) == 0) ? NEEDED - 1 : NEEDED;
    issue_event(OP_REQUEST, KIND_W'($urandom), $urandom, RANK_W'($urandom));
    while (acks_left > 0) begin
      case ($urandom_range(9))
        6, 7: issue_event(OP_MESSAGE, MSG_REQ, pick_stamp(), RANK_W'($urandom));
        8:    issue_event(OP_REQUEST, KIND_W'($urandom), $urandom, RANK_W'($urandom));
        9:    issue_event(OP_MESSAGE, MSG_FIN, pick_stamp(), RANK_W'($urandom));
        default: begin
          issue_event(OP_MESSAGE, MSG_ACK, pick_stamp(), RANK_W'($urandom));
          acks_left--;
        end
      endcase
    end
    // Overfill the deferred queue once in a while.
    queued = ($urandom_range(4) == 0) ? $urandom_range(QDEPTH, QDEPTH + 2)
                                      : $urandom_range(0, 3);
    repeat (queued) issue_event(OP_MESSAGE, MSG_REQ, pick_stamp(), RANK_W'($urandom));
    if ($urandom_range(9) != 0) begin
      issue_event(OP_RELEASE, KIND_W'($urandom), $urandom, RANK_W'($urandom));
    end
  endtask

  // Fully random beats, unknown codes included.
  task automatic run_noise();
    repeat ($urandom_range(1, 4)) begin
      issue_event(OP_W'($urandom), KIND_W'($urandom),
                  ($urandom_range(1) == 0) ? $urandom : pick_stamp(), RANK_W'($urandom));
    end
  endtask

  initial begin
    int                phase;
    int                base;
    logic [RANK_W-1:0] phase_rank;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, rank 3 so ties can go either way; clock starts at zero.
    set_rank(3'd3);
    issue_event(OP_UNKNOWN, MSG_REQ, '0, '0);               // ignored operation
    issue_event(OP_MESSAGE, MSG_UNKNOWN, '1, 3'd7);         // ignored message kind
    issue_event(OP_RELEASE, MSG_REQ, '0, '0);               // release while idle
    issue_event(OP_MESSAGE, MSG_ACK, 32'd5, 3'd2);          // stray ACK bumps clock
    issue_event(OP_MESSAGE, MSG_REQ, '1, 3'd7);             // clock wraps, idle grant
    issue_event(OP_REQUEST, MSG_REQ, '0, '0);               // full REQ broadcast
    issue_event(OP_REQUEST, MSG_REQ, '0, '0);               // request while requesting
    issue_event(OP_MESSAGE, MSG_REQ, 32'd2, 3'd1);          // tie, lower rank wins
    issue_event(OP_MESSAGE, MSG_REQ, 32'd2, 3'd6);          // tie, higher rank waits
    issue_event(OP_MESSAGE, MSG_REQ, 32'd1, 3'd5);          // older stamp wins
    issue_event(OP_MESSAGE, MSG_REQ, '1, 3'd0);             // newer stamp waits, wraps
    repeat (NEEDED) issue_event(OP_MESSAGE, MSG_ACK, '0, 3'd2);
    issue_event(OP_REQUEST, MSG_REQ, '0, '0);               // request inside section
    issue_event(OP_MESSAGE, MSG_REQ, '0, 3'd4);             // queued while inside
    issue_event(OP_RELEASE, MSG_ACK, '1, 3'd7);             // drain deferred ACKs
    issue_event(OP_RELEASE, MSG_ACK, '1, 3'd7);             // second release ignored
    issue_event(OP_MESSAGE, MSG_FIN, '0, 3'd1);

    // Random part: one rank per phase, rank extremes first; keep gaps off in one
    // phase so beats run back to back for a long stretch.
    base = items_sent;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       phase_rank = '0;
        1:       phase_rank = '1;
        default: phase_rank = RANK_W'($urandom);
      endcase
      set_rank(phase_rank);
      gaps_on = (phase != 1);
      while (items_sent < base + (phase + 1) * RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(9) < 7) run_session();
        else run_noise();
      end
    end

    wait_quiet();
    if (fail_count == 0 && owed_count == 0) begin
      $display("distributed_mutex_node_core test passed");
    end else begin
      $display("distributed_mutex_node_core test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/dmn_pkg.sv
hdl/dmn_ctrl.sv
hdl/dmn_datapath.sv
hdl/distributed_mutex_node_core.sv
tb/dmn_event_checker.sv
tb/tb.sv
